>>> design/psmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_pkg
// Request and status codes, field widths and sequencer states of the
// per-sender mailbox.
// ----------------------------------------------------------------------------
package psmc_pkg;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 3;

    localparam logic [REQ_W-1:0] REQ_SEND   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ANY    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FROM   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESULT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIED   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_CHAN = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FROM_CHK,
        ST_WRITE,
        ST_PICK,
        ST_TAKE,
        ST_TAKE_WAIT,
        ST_RES_CH,
        ST_RES_RD,
        ST_RES_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_HEAD_INC,
        ST_DIED,
        ST_DONE
    } t_state;

endpackage

>>> design/psmc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_req_if
// Request channel of the mailbox: valid/ready and the request fields.
// ----------------------------------------------------------------------------
interface psmc_req_if #(
    parameter int KEY_W = 16,
    parameter int MSG_W = 64
) ();
    logic                        valid;
    logic                        ready;
    logic [psmc_pkg::REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]            sender_id;
    logic [MSG_W-1:0]            message;
    logic                        message_is_result;

    modport source (output valid, output req_type, output sender_id, output message,
                    output message_is_result, input ready);
    modport sink   (input valid, input req_type, input sender_id, input message,
                    input message_is_result, output ready);
endinterface

>>> design/psmc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_rsp_if
// Response channel of the mailbox: valid/ready and the result fields.
// ----------------------------------------------------------------------------
interface psmc_rsp_if #(
    parameter int MSG_W = 64
) ();
    logic                           valid;
    logic                           ready;
    logic [psmc_pkg::STATUS_W-1:0]  status;
    logic [MSG_W-1:0]               received;
    logic                           received_is_result;
    logic [psmc_pkg::USED_W-1:0]    channel_used;

    modport source (output valid, output status, output received,
                    output received_is_result, output channel_used, input ready);
    modport sink   (input valid, input status, input received,
                    input received_is_result, input channel_used, output ready);
endinterface

>>> design/per_sender_mailbox_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_sender_mailbox_channels
// Mailbox with one FIFO ring per sender channel, driven by a small sequencer.
//
// Channels: i_req takes one request (send, receive any, receive from sender,
// receive result, sender died); o_rsp returns exactly one response for it.
// Both use valid/ready; a request is taken when valid and ready are high.
// One request is worked at a time; ready is high only while the sequencer
// waits for a new request. The response sits in an output register, so the
// next request is taken while a response still waits.
// Steps: send runs the owner and claim scan, one channel a cycle, then
//   writes; receive-from runs the same scan, then reads the head entry;
//   receive-any scans from the cursor; receive-result scans from the cursor,
//   reads each entry through the store read port and closes the gap left
//   by the taken entry.
// Reset clears all channel bindings, ring counters and the scan cursor; the
// store needs no clearing. When the receiver stalls, the finished response
// holds and the sequencer waits in its last state.
// ----------------------------------------------------------------------------
module per_sender_mailbox_channels #(
    parameter int CHANNELS   = 8,
    parameter int RING_DEPTH = 64,
    parameter int MSG_WIDTH  = 64,
    parameter int KEY_WIDTH  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psmc_req_if.sink     i_req,
    psmc_rsp_if.source   o_rsp
);
    localparam int XW = $clog2(CHANNELS);
    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(2 * RING_DEPTH);
    localparam int AW = $clog2(CHANNELS * RING_DEPTH);
    localparam int DW = MSG_WIDTH + 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(2 * RING_DEPTH - 1);
    localparam logic [CW-1:0] RD_CNT   = CW'(RING_DEPTH);
    localparam logic [PW-1:0] POS_LAST = PW'(RING_DEPTH - 1);
    localparam logic [XW-1:0] CH_LAST  = XW'(CHANNELS - 1);

    function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
        cnt_inc = (c == CNT_LAST) ? '0 : CW'(c + 1'b1);
    endfunction

    function automatic logic [CW-1:0] fill_of(input logic [CW-1:0] t, input logic [CW-1:0] h);
        logic [CW:0] wide;
        wide = (t >= h) ? (CW + 1)'(t - h)
                        : (CW + 1)'((CW + 1)'(t) + (CW + 1)'(2 * RING_DEPTH) - (CW + 1)'(h));
        fill_of = wide[CW-1:0];
    endfunction

    function automatic logic [PW-1:0] pos_of(input logic [CW-1:0] c);
        pos_of = (c >= RD_CNT) ? PW'(c - RD_CNT) : PW'(c);
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        pos_inc = (p == POS_LAST) ? '0 : PW'(p + 1'b1);
    endfunction

    function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
        pos_dec = (p == '0) ? POS_LAST : PW'(p - 1'b1);
    endfunction

    function automatic logic [XW-1:0] ch_inc(input logic [XW-1:0] x);
        ch_inc = (x == CH_LAST) ? '0 : XW'(x + 1'b1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [PW-1:0] p);
        addr_of = AW'(AW'(x) * AW'(RING_DEPTH) + AW'(p));
    endfunction

    psmc_pkg::t_state r_state, n_state;

    logic [KEY_WIDTH-1:0] r_owner [CHANNELS];
    logic [KEY_WIDTH-1:0] n_owner [CHANNELS];
    logic                 r_dead  [CHANNELS];
    logic                 n_dead  [CHANNELS];
    logic [CW-1:0]        r_head  [CHANNELS];
    logic [CW-1:0]        n_head  [CHANNELS];
    logic [CW-1:0]        r_tail  [CHANNELS];
    logic [CW-1:0]        n_tail  [CHANNELS];
    logic [XW-1:0]        r_cursor, n_cursor;

    logic [psmc_pkg::REQ_W-1:0] r_req, n_req;
    logic [KEY_WIDTH-1:0]       r_key, n_key;
    logic [MSG_WIDTH-1:0]       r_msg, n_msg;
    logic                       r_tag, n_tag;

    logic [XW-1:0] r_idx, n_idx;
    logic [XW-1:0] r_step, n_step;
    logic          r_hit, n_hit;
    logic [XW-1:0] r_hit_idx, n_hit_idx;
    logic          r_clm, n_clm;
    logic [XW-1:0] r_clm_idx, n_clm_idx;
    logic          r_clm_unb, n_clm_unb;
    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [psmc_pkg::STATUS_W-1:0] r_status, n_status;
    logic [MSG_WIDTH-1:0]          r_got, n_got;
    logic                          r_got_tag, n_got_tag;
    logic [psmc_pkg::USED_W-1:0]   r_used, n_used;

    logic                          r_ov, n_ov;
    logic [psmc_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [MSG_WIDTH-1:0]          r_o_got, n_o_got;
    logic                          r_o_tag, n_o_tag;
    logic [psmc_pkg::USED_W-1:0]   r_o_used, n_o_used;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    logic [KEY_WIDTH-1:0] cur_owner;
    logic                 cur_dead;
    logic [CW-1:0]        cur_head;
    logic [CW-1:0]        cur_tail;
    logic [CW-1:0]        cur_fill;
    logic                 cur_ready;
    logic                 step_last;
    logic                 ring_end;

    assign cur_owner = r_owner[r_idx];
    assign cur_dead  = r_dead[r_idx];
    assign cur_head  = r_head[r_idx];
    assign cur_tail  = r_tail[r_idx];
    assign cur_fill  = fill_of(cur_tail, cur_head);
    assign cur_ready = (cur_owner != '0) && (cur_fill != '0);
    assign step_last = (r_step == CH_LAST);
    assign ring_end  = (CW'(r_k + 1'b1) == r_cnt);

    psmc_store #(
        .DEPTH (CHANNELS * RING_DEPTH),
        .WIDTH (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready              = (r_state == psmc_pkg::ST_IDLE);
    assign o_rsp.valid              = r_ov;
    assign o_rsp.status             = r_o_status;
    assign o_rsp.received           = r_o_got;
    assign o_rsp.received_is_result = r_o_tag;
    assign o_rsp.channel_used       = r_o_used;

    always_comb begin
        n_state = r_state;
        case (r_state)
            psmc_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.req_type)
                        psmc_pkg::REQ_SEND, psmc_pkg::REQ_FROM: begin
                            n_state = (i_req.sender_id == '0) ? psmc_pkg::ST_DONE
                                                              : psmc_pkg::ST_SCAN;
                        end
                        psmc_pkg::REQ_ANY:    n_state = psmc_pkg::ST_PICK;
                        psmc_pkg::REQ_RESULT: n_state = psmc_pkg::ST_RES_CH;
                        psmc_pkg::REQ_DIED:   n_state = psmc_pkg::ST_DIED;
                        default:              n_state = psmc_pkg::ST_DONE;
                    endcase
                end
            end
            psmc_pkg::ST_SCAN: begin
                if (cur_owner == r_key || step_last) begin
                    n_state = psmc_pkg::ST_DECIDE;
                end
            end
            psmc_pkg::ST_DECIDE: begin
                if (r_req == psmc_pkg::REQ_SEND) begin
                    n_state = (r_hit || r_clm) ? psmc_pkg::ST_WRITE : psmc_pkg::ST_DONE;
                end else begin
                    n_state = r_hit ? psmc_pkg::ST_FROM_CHK : psmc_pkg::ST_DONE;
                end
            end
            psmc_pkg::ST_FROM_CHK: begin
                n_state = (cur_fill != '0) ? psmc_pkg::ST_TAKE : psmc_pkg::ST_DONE;
            end
            psmc_pkg::ST_WRITE: n_state = psmc_pkg::ST_DONE;
            psmc_pkg::ST_PICK: begin
                if (cur_ready) begin
                    n_state = psmc_pkg::ST_TAKE;
                end else if (step_last) begin
                    n_state = psmc_pkg::ST_DONE;
                end
            end
            psmc_pkg::ST_TAKE:      n_state = psmc_pkg::ST_TAKE_WAIT;
            psmc_pkg::ST_TAKE_WAIT: n_state = psmc_pkg::ST_DONE;
            psmc_pkg::ST_RES_CH: begin
                if (cur_ready) begin
                    n_state = psmc_pkg::ST_RES_RD;
                end else if (step_last) begin
                    n_state = psmc_pkg::ST_DONE;
                end
            end
            psmc_pkg::ST_RES_RD: n_state = psmc_pkg::ST_RES_CHK;
            psmc_pkg::ST_RES_CHK: begin
                if (mem_rdata[MSG_WIDTH]) begin
                    n_state = (r_k == '0) ? psmc_pkg::ST_HEAD_INC : psmc_pkg::ST_SHIFT_RD;
                end else if (ring_end) begin
                    n_state = step_last ? psmc_pkg::ST_DONE : psmc_pkg::ST_RES_CH;
                end else begin
                    n_state = psmc_pkg::ST_RES_RD;
                end
            end
            psmc_pkg::ST_SHIFT_RD: n_state = psmc_pkg::ST_SHIFT_WR;
            psmc_pkg::ST_SHIFT_WR: begin
                n_state = (r_k == CW'(1)) ? psmc_pkg::ST_HEAD_INC : psmc_pkg::ST_SHIFT_RD;
            end
            psmc_pkg::ST_HEAD_INC: n_state = psmc_pkg::ST_DONE;
            psmc_pkg::ST_DIED:     n_state = psmc_pkg::ST_DONE;
            psmc_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = psmc_pkg::ST_IDLE;
                end
            end
            default: n_state = psmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_owner    = r_owner;
        n_dead     = r_dead;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cursor   = r_cursor;
        n_req      = r_req;
        n_key      = r_key;
        n_msg      = r_msg;
        n_tag      = r_tag;
        n_idx      = r_idx;
        n_step     = r_step;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_clm      = r_clm;
        n_clm_idx  = r_clm_idx;
        n_clm_unb  = r_clm_unb;
        n_pos      = r_pos;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_got      = r_got;
        n_got_tag  = r_got_tag;
        n_used     = r_used;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_got    = r_o_got;
        n_o_tag    = r_o_tag;
        n_o_used   = r_o_used;
        mem_we     = 1'b0;
        mem_waddr  = addr_of(r_idx, pos_of(cur_tail));
        mem_wdata  = {r_tag, r_msg};
        mem_raddr  = addr_of(r_idx, r_pos);
        case (r_state)
            psmc_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_req     = i_req.req_type;
                    n_key     = i_req.sender_id;
                    n_msg     = i_req.message;
                    n_tag     = i_req.message_is_result;
                    n_idx     = (i_req.req_type == psmc_pkg::REQ_ANY ||
                                 i_req.req_type == psmc_pkg::REQ_RESULT) ? r_cursor : '0;
                    n_step    = '0;
                    n_hit     = 1'b0;
                    n_clm     = 1'b0;
                    n_status  = (i_req.req_type == psmc_pkg::REQ_SEND)
                              ? psmc_pkg::STATUS_NO_CHAN : psmc_pkg::STATUS_EMPTY;
                    n_got     = '0;
                    n_got_tag = 1'b0;
                    n_used    = '0;
                end
            end
            psmc_pkg::ST_SCAN: begin
                if (cur_owner == r_key) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end else if (!r_clm && (cur_owner == '0 || (cur_dead && cur_fill == '0))) begin
                    n_clm     = 1'b1;
                    n_clm_idx = r_idx;
                    n_clm_unb = (cur_owner == '0);
                end
                n_idx  = ch_inc(r_idx);
                n_step = XW'(r_step + 1'b1);
            end
            psmc_pkg::ST_DECIDE: begin
                if (r_hit) begin
                    n_idx = r_hit_idx;
                end else if (r_clm) begin
                    n_idx = r_clm_idx;
                    if (r_req == psmc_pkg::REQ_SEND) begin
                        n_owner[r_clm_idx] = r_key;
                        n_dead[r_clm_idx]  = 1'b0;
                        if (r_clm_unb) begin
                            n_head[r_clm_idx] = '0;
                            n_tail[r_clm_idx] = '0;
                        end
                    end
                end
            end
            psmc_pkg::ST_WRITE: begin
                n_used = psmc_pkg::USED_W'(r_idx);
                if (cur_fill >= RD_CNT) begin
                    n_status = psmc_pkg::STATUS_FULL;
                end else begin
                    mem_we        = 1'b1;
                    n_tail[r_idx] = cnt_inc(cur_tail);
                    n_status      = psmc_pkg::STATUS_OK;
                end
            end
            psmc_pkg::ST_PICK: begin
                if (cur_ready) begin
                    n_cursor = ch_inc(r_idx);
                end else begin
                    n_idx  = ch_inc(r_idx);
                    n_step = XW'(r_step + 1'b1);
                end
            end
            psmc_pkg::ST_TAKE: begin
                mem_raddr     = addr_of(r_idx, pos_of(cur_head));
                n_head[r_idx] = cnt_inc(cur_head);
            end
            psmc_pkg::ST_TAKE_WAIT: begin
                n_got     = mem_rdata[MSG_WIDTH-1:0];
                n_got_tag = mem_rdata[MSG_WIDTH];
                n_status  = psmc_pkg::STATUS_OK;
                n_used    = psmc_pkg::USED_W'(r_idx);
            end
            psmc_pkg::ST_RES_CH: begin
                if (cur_ready) begin
                    n_pos = pos_of(cur_head);
                    n_k   = '0;
                    n_cnt = cur_fill;
                end else begin
                    n_idx  = ch_inc(r_idx);
                    n_step = XW'(r_step + 1'b1);
                end
            end
            psmc_pkg::ST_RES_CHK: begin
                if (mem_rdata[MSG_WIDTH]) begin
                    n_got     = mem_rdata[MSG_WIDTH-1:0];
                    n_got_tag = 1'b1;
                    n_status  = psmc_pkg::STATUS_OK;
                    n_used    = psmc_pkg::USED_W'(r_idx);
                end else if (ring_end) begin
                    n_idx  = ch_inc(r_idx);
                    n_step = XW'(r_step + 1'b1);
                end else begin
                    n_k   = CW'(r_k + 1'b1);
                    n_pos = pos_inc(r_pos);
                end
            end
            psmc_pkg::ST_SHIFT_RD: begin
                mem_raddr = addr_of(r_idx, pos_dec(r_pos));
            end
            psmc_pkg::ST_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(r_idx, r_pos);
                mem_wdata = mem_rdata;
                n_pos     = pos_dec(r_pos);
                n_k       = CW'(r_k - 1'b1);
            end
            psmc_pkg::ST_HEAD_INC: begin
                n_head[r_idx] = cnt_inc(cur_head);
            end
            psmc_pkg::ST_DIED: begin
                n_status = psmc_pkg::STATUS_OK;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_key != '0 && r_owner[i] == r_key) begin
                        n_dead[i] = 1'b1;
                    end
                end
            end
            psmc_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_got    = r_got;
                    n_o_tag    = r_got_tag;
                    n_o_used   = r_used;
                end
            end
            default: begin
                n_ov = r_ov && !o_rsp.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psmc_pkg::ST_IDLE;
            r_cursor <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_owner[i] <= '0;
                r_dead[i]  <= 1'b0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_ov     <= n_ov;
            r_owner  <= n_owner;
            r_dead   <= n_dead;
            r_head   <= n_head;
            r_tail   <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_msg      <= n_msg;
        r_tag      <= n_tag;
        r_idx      <= n_idx;
        r_step     <= n_step;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_clm      <= n_clm;
        r_clm_idx  <= n_clm_idx;
        r_clm_unb  <= n_clm_unb;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_got      <= n_got;
        r_got_tag  <= n_got_tag;
        r_used     <= n_used;
        r_o_status <= n_o_status;
        r_o_got    <= n_o_got;
        r_o_tag    <= n_o_tag;
        r_o_used   <= n_o_used;
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in work");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psmc_pkg::ST_WRITE || r_state == psmc_pkg::ST_TAKE) |->
        (cur_fill <= RD_CNT))
        else $error("ring fill beyond depth");

    a_scan_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psmc_pkg::ST_RES_CHK) |-> (r_k < r_cnt))
        else $error("result scan past ring tail");

    a_shift_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psmc_pkg::ST_SHIFT_WR) |-> (r_k != '0))
        else $error("gap shift with zero offset");
endmodule

>>> design/psmc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_store
// Message store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psmc_store #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> tb/sv/per_sender_mailbox_channels_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_sender_mailbox_channels_test
// Drives send, receive and death requests into the per-sender mailbox under
// random idling and back-pressure, and checks every response field against
// an in-bench mailbox predictor kept in request order.
// ----------------------------------------------------------------------------
module per_sender_mailbox_channels_test;

    localparam int NCH   = 8;
    localparam int DEPTH = 64;
    localparam int CMOD  = 2 * DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [psmc_pkg::STATUS_W-1:0] status;
        logic [63:0]                   received;
        logic                          is_result;
        logic [psmc_pkg::USED_W-1:0]   chan;
    } t_reply;

    class mailbox_scoreboard;
        logic [15:0] owner [NCH];
        bit          dead [NCH];
        int          head [NCH];
        int          tail [NCH];
        logic [63:0] msg_mem [NCH][DEPTH];
        bit          tag_mem [NCH][DEPTH];
        int          cursor;
        t_reply      pending [$];
        int          errors;

        function new();
            for (int i = 0; i < NCH; i++) begin
                owner[i] = 0; dead[i] = 0; head[i] = 0; tail[i] = 0;
            end
            cursor = 0;
            errors = 0;
        endfunction

        function int fill(int c);
            return (tail[c] + CMOD - head[c]) % CMOD;
        endfunction

        function int owner_of(logic [15:0] key);
            for (int i = 0; i < NCH; i++) if (owner[i] == key) return i;
            return -1;
        endfunction

        function void take(int c, int off, ref t_reply r);
            int h;
            int p;
            h = head[c];
            p = (h + off) % DEPTH;
            r.received = msg_mem[c][p];
            r.is_result = tag_mem[c][p];
            for (int j = off; j > 0; j--) begin
                msg_mem[c][(h + j) % DEPTH] = msg_mem[c][(h + j - 1) % DEPTH];
                tag_mem[c][(h + j) % DEPTH] = tag_mem[c][(h + j - 1) % DEPTH];
            end
            head[c] = (h + 1) % CMOD;
            r.status = psmc_pkg::STATUS_OK;
            r.chan = 3'(c);
        endfunction

        function int chan_of_key(logic [15:0] key);
            return (key != 0) ? owner_of(key) : -1;
        endfunction

        function void note_request(logic [2:0] rt, logic [15:0] key, logic [63:0] m, bit t);
            t_reply r;
            int c;
            int ch;
            bit done;
            r = '{psmc_pkg::STATUS_EMPTY, 64'd0, 1'b0, 3'd0};
            case (rt)
                psmc_pkg::REQ_SEND: begin
                    c = chan_of_key(key);
                    if (key != 0 && c < 0) begin
                        for (int i = 0; i < NCH && c < 0; i++) begin
                            if (owner[i] == 0) begin
                                head[i] = 0; tail[i] = 0; c = i;
                            end else if (dead[i] && fill(i) == 0) begin
                                c = i;
                            end
                        end
                        if (c >= 0) begin
                            owner[c] = key; dead[c] = 0;
                        end
                    end
                    if (c < 0) begin
                        r.status = psmc_pkg::STATUS_NO_CHAN;
                    end else if (fill(c) >= DEPTH) begin
                        r.status = psmc_pkg::STATUS_FULL; r.chan = 3'(c);
                    end else begin
                        msg_mem[c][tail[c] % DEPTH] = m;
                        tag_mem[c][tail[c] % DEPTH] = t;
                        tail[c] = (tail[c] + 1) % CMOD;
                        r.status = psmc_pkg::STATUS_OK; r.chan = 3'(c);
                    end
                end
                psmc_pkg::REQ_ANY: begin
                    for (int n = 0; n < NCH; n++) begin
                        ch = (cursor + n) % NCH;
                        if (owner[ch] != 0 && fill(ch) != 0) begin
                            cursor = (cursor + n + 1) % NCH;
                            take(ch, 0, r);
                            break;
                        end
                    end
                end
                psmc_pkg::REQ_FROM: begin
                    c = chan_of_key(key);
                    if (c >= 0 && fill(c) != 0) take(c, 0, r);
                end
                psmc_pkg::REQ_RESULT: begin
                    done = 0;
                    for (int n = 0; n < NCH && !done; n++) begin
                        ch = (cursor + n) % NCH;
                        if (owner[ch] == 0) continue;
                        for (int k = 0; k < fill(ch); k++) begin
                            if (tag_mem[ch][(head[ch] + k) % DEPTH]) begin
                                take(ch, k, r);
                                done = 1;
                                break;
                            end
                        end
                    end
                end
                psmc_pkg::REQ_DIED: begin
                    r.status = psmc_pkg::STATUS_OK;
                    if (key != 0)
                        for (int i = 0; i < NCH; i++) if (owner[i] == key) dead[i] = 1;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.received !== exp.received) begin
                $display("%0t: received exp %h got %h", $time, exp.received, got.received);
                errors++;
            end
            if (got.is_result !== exp.is_result) begin
                $display("%0t: is_result exp %0d got %0d", $time, exp.is_result, got.is_result);
                errors++;
            end
            if (got.chan !== exp.chan) begin
                $display("%0t: channel exp %0d got %0d", $time, exp.chan, got.chan);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    psmc_req_if #(.KEY_W(16), .MSG_W(64)) req_ch ();
    psmc_rsp_if #(.MSG_W(64)) rsp_ch ();

    per_sender_mailbox_channels dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    mailbox_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;
    logic [15:0] keys [6];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        req_ch.valid = 0;
        req_ch.req_type = psmc_pkg::REQ_SEND;
        req_ch.sender_id = 0;
        req_ch.message = 0;
        req_ch.message_is_result = 0;
        rsp_ch.ready = 0;
        send_idle_pct = 13;
        recv_idle_pct = 71;
        recv_hold = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_reply({rsp_ch.status, rsp_ch.received,
                                   rsp_ch.received_is_result, rsp_ch.channel_used});
            rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic issue(logic [2:0] rt, logic [15:0] key, logic [63:0] m, bit t);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= rt;
        req_ch.sender_id <= key;
        req_ch.message <= m;
        req_ch.message_is_result <= t;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(rt, key, m, t);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [2:0] rt;
        logic [15:0] key;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            key = ($urandom_range(19) == 0) ? 16'($urandom) : keys[$urandom_range(5)];
            if ($urandom_range(49) == 0) key = 0;
            if (r < 45) rt = psmc_pkg::REQ_SEND;
            else if (r < 63) rt = psmc_pkg::REQ_ANY;
            else if (r < 78) rt = psmc_pkg::REQ_FROM;
            else if (r < 92) rt = psmc_pkg::REQ_RESULT;
            else if (r < 97) rt = psmc_pkg::REQ_DIED;
            else rt = 3'($urandom_range(7, 5));
            issue(rt, key, rand64(), $urandom_range(2) == 0);
        end
    endtask

    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        keys = '{16'h0001, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h1234, 16'h8000};
        // directed
        issue(psmc_pkg::REQ_ANY, 16'h0001, 0, 0);
        issue(psmc_pkg::REQ_RESULT, 0, 0, 0);
        issue(psmc_pkg::REQ_SEND, 0, 64'h1, 0);
        issue(psmc_pkg::REQ_FROM, 0, 0, 0);
        issue(psmc_pkg::REQ_DIED, 0, 0, 0);
        issue(psmc_pkg::REQ_SEND, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        issue(psmc_pkg::REQ_SEND, 16'hFFFF, 64'h0, 0);
        issue(psmc_pkg::REQ_SEND, 16'hFFFF, 64'hAAAA_5555_AAAA_5555, 1);
        issue(psmc_pkg::REQ_SEND, 16'hFFFF, 64'h5555_AAAA_5555_AAAA, 0);
        issue(psmc_pkg::REQ_RESULT, 0, 0, 0);
        issue(psmc_pkg::REQ_FROM, 16'hFFFF, 0, 0);
        issue(psmc_pkg::REQ_DIED, 16'h0001, 0, 0);
        issue(psmc_pkg::REQ_DIED, 16'h7777, 0, 0);
        issue(psmc_pkg::REQ_SEND, 16'h0001, 64'h77, 0);
        issue(psmc_pkg::REQ_ANY, 0, 0, 0);
        issue(3'd5, 16'h1, 64'h1, 1);
        issue(3'd7, 16'h1, 64'h1, 1);
        for (int i = 0; i < 9; i++) issue(psmc_pkg::REQ_SEND, 16'h100 + i, i, 0);
        for (int i = 0; i < 66; i++) issue(psmc_pkg::REQ_SEND, 16'h5A5A, rand64(), i == 30);
        for (int i = 0; i < 6; i++) issue(psmc_pkg::REQ_DIED, 16'h100 + i, 0, 0);
        for (int i = 0; i < 12; i++) issue(psmc_pkg::REQ_ANY, 0, 0, 0);
        drain();
        // long receiver hold-off while sender keeps going
        recv_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
            begin
                random_phase(30);
                drain();
            end
        join
        drain();
        random_phase(500);
        drain();
        send_idle_pct = 71;
        recv_idle_pct = 13;
        random_phase(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(450);
        drain();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> filelist.f
design/psmc_pkg.sv
design/psmc_req_if.sv
design/psmc_rsp_if.sv
design/psmc_store.sv
design/per_sender_mailbox_channels.sv
tb/sv/per_sender_mailbox_channels_test.sv
